### src/ftec_pkg.sv
// ftec_pkg: shared types, codes and the integral update schedule for the
// two-electron contraction unit. No dependencies.
`default_nettype none

package ftec_pkg;

  typedef enum logic [2:0] {
    OP_LOAD_C = 3'd0,
    OP_LOAD_X = 3'd1,
    OP_INT    = 3'd2,
    OP_CLR    = 3'd3,
    OP_RDG    = 3'd4
  } op_t;

  localparam logic [1:0] TS_BOTH = 2'd0;
  localparam logic [1:0] TS_COUL = 2'd1;
  localparam logic [1:0] TS_EXCH = 2'd2;

  localparam logic [1:0] REG_BASIS = 2'd0;
  localparam logic [1:0] REG_RESTR = 2'd1;
  localparam logic [1:0] REG_TERM  = 2'd2;

  // index selectors
  localparam logic [1:0] XI = 2'd0;
  localparam logic [1:0] XJ = 2'd1;
  localparam logic [1:0] XK = 2'd2;
  localparam logic [1:0] XL = 2'd3;

  localparam int IN_W   = 64;
  localparam int OUT_W  = 56;
  localparam int G_W    = 48;
  localparam int D_W    = 36;

  // one G update: target (tr,tc), density at (ar,ac), plus (ac,ar) when hasb
  typedef struct packed {
    logic [1:0] tr;
    logic [1:0] tc;
    logic [1:0] ar;
    logic [1:0] ac;
    logic       hasb;
    logic       last;
  } upd_t;

  function automatic upd_t mk(input logic [1:0] tr, input logic [1:0] tc,
                              input logic [1:0] ar, input logic [1:0] ac,
                              input logic hasb, input logic last);
    upd_t u;
    u.tr = tr; u.tc = tc; u.ar = ar; u.ac = ac; u.hasb = hasb; u.last = last;
    return u;
  endfunction

  function automatic logic [3:0] pattern(input logic [5:0] i, input logic [5:0] j,
                                         input logic [5:0] k, input logic [5:0] l,
                                         input logic coul);
    logic eij, ekl;
    logic [3:0] p;
    eij = (i == j);
    ekl = (k == l);
    if (eij && ekl && i == k) p = 4'd1;
    else if (!eij && ekl && j == k) p = 4'd2;
    else if (!eij && i == k && j == l) p = 4'd3;
    else if (eij && ekl && i != k) p = 4'd4;
    else if (eij && !ekl && i == k) p = 4'd5;
    else if (!eij && !ekl && j == l && i != k) p = 4'd6;
    else if (!eij && ekl && i != k && j != k) p = 4'd7;
    else if (eij && !ekl && i != k && i != l) p = 4'd8;
    else if (!eij && !ekl && j == k && (!coul || i != l)) p = 4'd9;
    else if (!eij && !ekl && i == k && j != l) p = 4'd10;
    else p = 4'd11;
    return p;
  endfunction

  function automatic upd_t coul_upd(input logic [3:0] pat, input logic [2:0] step);
    upd_t u;
    case (pat)
      4'd1: u = mk(XI, XI, XI, XI, 1'b0, 1'b1);
      4'd2: case (step)
        3'd0: u = mk(XI, XJ, XJ, XJ, 1'b0, 1'b0);
        3'd1: u = mk(XJ, XI, XJ, XJ, 1'b0, 1'b0);
        default: u = mk(XJ, XJ, XI, XJ, 1'b1, 1'b1);
      endcase
      4'd3: case (step)
        3'd0: u = mk(XI, XJ, XI, XJ, 1'b1, 1'b0);
        default: u = mk(XJ, XI, XI, XJ, 1'b1, 1'b1);
      endcase
      4'd4: case (step)
        3'd0: u = mk(XI, XI, XK, XK, 1'b0, 1'b0);
        default: u = mk(XK, XK, XI, XI, 1'b0, 1'b1);
      endcase
      4'd5: case (step)
        3'd0: u = mk(XI, XI, XI, XL, 1'b1, 1'b0);
        3'd1: u = mk(XL, XI, XI, XI, 1'b0, 1'b0);
        default: u = mk(XI, XL, XI, XI, 1'b0, 1'b1);
      endcase
      4'd6: case (step)
        3'd0: u = mk(XI, XJ, XK, XJ, 1'b1, 1'b0);
        3'd1: u = mk(XJ, XI, XK, XJ, 1'b1, 1'b0);
        3'd2: u = mk(XK, XJ, XI, XJ, 1'b1, 1'b0);
        default: u = mk(XJ, XK, XI, XJ, 1'b1, 1'b1);
      endcase
      4'd7: case (step)
        3'd0: u = mk(XI, XJ, XK, XK, 1'b0, 1'b0);
        3'd1: u = mk(XJ, XI, XK, XK, 1'b0, 1'b0);
        default: u = mk(XK, XK, XI, XJ, 1'b1, 1'b1);
      endcase
      4'd8: case (step)
        3'd0: u = mk(XI, XI, XK, XL, 1'b1, 1'b0);
        3'd1: u = mk(XK, XL, XI, XI, 1'b0, 1'b0);
        default: u = mk(XL, XK, XI, XI, 1'b0, 1'b1);
      endcase
      4'd9: case (step)
        3'd0: u = mk(XI, XJ, XJ, XL, 1'b1, 1'b0);
        3'd1: u = mk(XJ, XI, XJ, XL, 1'b1, 1'b0);
        3'd2: u = mk(XJ, XL, XI, XJ, 1'b1, 1'b0);
        default: u = mk(XL, XJ, XI, XJ, 1'b1, 1'b1);
      endcase
      4'd10: case (step)
        3'd0: u = mk(XI, XJ, XI, XL, 1'b1, 1'b0);
        3'd1: u = mk(XJ, XI, XI, XL, 1'b1, 1'b0);
        3'd2: u = mk(XI, XL, XI, XJ, 1'b1, 1'b0);
        default: u = mk(XL, XI, XI, XJ, 1'b1, 1'b1);
      endcase
      default: case (step)
        3'd0: u = mk(XI, XJ, XK, XL, 1'b1, 1'b0);
        3'd1: u = mk(XJ, XI, XK, XL, 1'b1, 1'b0);
        3'd2: u = mk(XK, XL, XI, XJ, 1'b1, 1'b0);
        default: u = mk(XL, XK, XI, XJ, 1'b1, 1'b1);
      endcase
    endcase
    return u;
  endfunction

  function automatic upd_t exch_upd(input logic [3:0] pat, input logic [2:0] step);
    upd_t u;
    case (pat)
      4'd1: u = mk(XI, XI, XI, XI, 1'b0, 1'b1);
      4'd2: case (step)
        3'd0: u = mk(XI, XJ, XJ, XJ, 1'b0, 1'b0);
        3'd1: u = mk(XJ, XI, XJ, XJ, 1'b0, 1'b0);
        default: u = mk(XJ, XJ, XI, XJ, 1'b1, 1'b1);
      endcase
      4'd3: case (step)
        3'd0: u = mk(XI, XJ, XI, XJ, 1'b0, 1'b0);
        3'd1: u = mk(XJ, XI, XJ, XI, 1'b0, 1'b0);
        3'd2: u = mk(XI, XI, XJ, XJ, 1'b0, 1'b0);
        default: u = mk(XJ, XJ, XI, XI, 1'b0, 1'b1);
      endcase
      4'd4: case (step)
        3'd0: u = mk(XI, XK, XK, XI, 1'b0, 1'b0);
        default: u = mk(XK, XI, XI, XK, 1'b0, 1'b1);
      endcase
      4'd5: case (step)
        3'd0: u = mk(XI, XI, XI, XL, 1'b1, 1'b0);
        3'd1: u = mk(XL, XI, XI, XI, 1'b0, 1'b0);
        default: u = mk(XI, XL, XI, XI, 1'b0, 1'b1);
      endcase
      4'd6: case (step)
        3'd0: u = mk(XI, XJ, XK, XJ, 1'b0, 1'b0);
        3'd1: u = mk(XJ, XI, XJ, XK, 1'b0, 1'b0);
        3'd2: u = mk(XK, XJ, XI, XJ, 1'b0, 1'b0);
        3'd3: u = mk(XJ, XK, XJ, XI, 1'b0, 1'b0);
        3'd4: u = mk(XI, XK, XJ, XJ, 1'b0, 1'b0);
        3'd5: u = mk(XK, XI, XJ, XJ, 1'b0, 1'b0);
        default: u = mk(XJ, XJ, XI, XK, 1'b1, 1'b1);
      endcase
      4'd7: case (step)
        3'd0: u = mk(XI, XK, XK, XJ, 1'b0, 1'b0);
        3'd1: u = mk(XJ, XK, XK, XI, 1'b0, 1'b0);
        3'd2: u = mk(XK, XJ, XI, XK, 1'b0, 1'b0);
        default: u = mk(XK, XI, XJ, XK, 1'b0, 1'b1);
      endcase
      4'd8: case (step)
        3'd0: u = mk(XI, XL, XK, XI, 1'b0, 1'b0);
        3'd1: u = mk(XI, XK, XL, XI, 1'b0, 1'b0);
        3'd2: u = mk(XK, XI, XI, XL, 1'b0, 1'b0);
        default: u = mk(XL, XI, XI, XK, 1'b0, 1'b1);
      endcase
      4'd9: case (step)
        3'd0: u = mk(XI, XL, XJ, XJ, 1'b0, 1'b0);
        3'd1: u = mk(XL, XI, XJ, XJ, 1'b0, 1'b0);
        3'd2: u = mk(XL, XJ, XI, XJ, 1'b0, 1'b0);
        3'd3: u = mk(XJ, XL, XJ, XI, 1'b0, 1'b0);
        3'd4: u = mk(XI, XJ, XL, XJ, 1'b0, 1'b0);
        3'd5: u = mk(XJ, XI, XJ, XL, 1'b0, 1'b0);
        default: u = mk(XJ, XJ, XI, XL, 1'b1, 1'b1);
      endcase
      4'd10: case (step)
        3'd0: u = mk(XI, XL, XI, XJ, 1'b0, 1'b0);
        3'd1: u = mk(XL, XI, XJ, XI, 1'b0, 1'b0);
        3'd2: u = mk(XL, XJ, XI, XI, 1'b0, 1'b0);
        3'd3: u = mk(XJ, XL, XI, XI, 1'b0, 1'b0);
        3'd4: u = mk(XI, XJ, XI, XL, 1'b0, 1'b0);
        3'd5: u = mk(XJ, XI, XL, XI, 1'b0, 1'b0);
        default: u = mk(XI, XI, XJ, XL, 1'b1, 1'b1);
      endcase
      default: case (step)
        3'd0: u = mk(XI, XL, XK, XJ, 1'b0, 1'b0);
        3'd1: u = mk(XJ, XL, XK, XI, 1'b0, 1'b0);
        3'd2: u = mk(XK, XJ, XI, XL, 1'b0, 1'b0);
        3'd3: u = mk(XJ, XK, XL, XI, 1'b0, 1'b0);
        3'd4: u = mk(XI, XK, XL, XJ, 1'b0, 1'b0);
        3'd5: u = mk(XL, XJ, XI, XK, 1'b0, 1'b0);
        3'd6: u = mk(XK, XI, XJ, XL, 1'b0, 1'b0);
        default: u = mk(XL, XI, XJ, XK, 1'b0, 1'b1);
      endcase
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

### src/fock_two_electron_contraction_unit.sv
// Two-electron Fock contraction unit: density stores, G accumulator memory
// and the per-integral update sequencer. Depends on ftec_pkg.
// Loads return no result; an index error result is loaded from idle; a G read passes
// S_GRD; a clear sweeps all MAX_BASIS_POW2^2 G entries, one G entry a cycle (MAX_BASIS
// rounded up to a power of two). Integral: 1 to 12 G updates, one item at a time; each
// runs S_RA, S_RB, S_DS, S_MU, S_RN, S_WR (two density reads, one G read-modify-write).
// Reset: synchronous; after reset a clearing pass of the same length as a
// clear sweeps G before the first request is taken. Densities are not cleared.
`default_nettype none

module fock_two_electron_contraction_unit #(
  parameter int MAX_BASIS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // op[2:0], idx_i[8:3], idx_j[14:9], idx_k[20:15], idx_l[26:21], value[58:27]
  input  wire logic [ftec_pkg::IN_W-1:0]     s_tdata,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // g_value[47:0], index_error[48], saturated[49]
  output logic [ftec_pkg::OUT_W-1:0]         m_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [6:0]                    cfg_wdata
);

  localparam int IW = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
  localparam int AW = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int NW = ($clog2(MAX_BASIS + 1) > 7) ? $clog2(MAX_BASIS + 1) : 7;
  localparam int GW = ftec_pkg::G_W;
  localparam int DW = ftec_pkg::D_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_GRD, S_RA, S_RB, S_DS, S_MU, S_RN, S_WR
  } state_t;

  state_t state;

  logic [6:0]  basis_count;
  logic        restricted_mode;
  logic [1:0]  term_select;

  logic [31:0]   cmem [DEPTH];
  logic [31:0]   xmem [DEPTH];
  logic [GW:0]   gmem [DEPTH];
  logic [31:0]   cq, xq;
  logic [GW:0]   gq;

  logic [5:0]  ri, rj, rk, rl;
  logic [31:0] value_r;
  logic [3:0]  pat_c, pat_x;
  logic        exch;
  logic [2:0]  step;
  logic [AW-1:0] clr_cnt;

  logic signed [DW-1:0] d1, dreg;
  logic signed [51:0]   pa;
  logic signed [52:0]   pb;
  logic signed [GW-1:0] term;

  // input unpack
  logic [2:0]  in_op;
  logic [5:0]  in_i, in_j, in_k, in_l;
  logic [31:0] in_val;
  assign in_op  = s_tdata[2:0];
  assign in_i   = s_tdata[8:3];
  assign in_j   = s_tdata[14:9];
  assign in_k   = s_tdata[20:15];
  assign in_l   = s_tdata[26:21];
  assign in_val = s_tdata[58:27];

  logic [NW-1:0] bound;
  logic          bad;
  logic          accept;
  logic [AW-1:0] in_addr;
  logic          res_load;

  assign bound = (NW'(basis_count) > NW'(MAX_BASIS)) ? NW'(MAX_BASIS) : NW'(basis_count);

  always_comb begin
    bad = (NW'(in_i) >= bound) || (NW'(in_j) >= bound);
    if (in_op == ftec_pkg::OP_INT)
      bad = bad || (NW'(in_k) >= bound) || (NW'(in_l) >= bound);
  end

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign in_addr  = {IW'(in_i), IW'(in_j)};

  // a result is loaded on a G read or on a failed index check
  assign res_load = (state == S_GRD)
                  || (accept && in_op != ftec_pkg::OP_CLR && in_op <= ftec_pkg::OP_RDG && bad);

  ftec_pkg::upd_t u;
  assign u = exch ? ftec_pkg::exch_upd(pat_x, step) : ftec_pkg::coul_upd(pat_c, step);

  function automatic logic [5:0] pick(input logic [1:0] s, input logic [5:0] a,
                                      input logic [5:0] b, input logic [5:0] c,
                                      input logic [5:0] d);
    logic [5:0] r;
    case (s)
      ftec_pkg::XI: r = a;
      ftec_pkg::XJ: r = b;
      ftec_pkg::XK: r = c;
      default:      r = d;
    endcase
    return r;
  endfunction

  logic [5:0] ar, ac, tr, tc;
  assign ar = pick(u.ar, ri, rj, rk, rl);
  assign ac = pick(u.ac, ri, rj, rk, rl);
  assign tr = pick(u.tr, ri, rj, rk, rl);
  assign tc = pick(u.tc, ri, rj, rk, rl);

  logic [AW-1:0] d_addr, g_addr, t_addr;
  assign t_addr = {IW'(tr), IW'(tc)};
  // second density read is the transpose of the first
  assign d_addr = (state == S_RB) ? {IW'(ac), IW'(ar)} : {IW'(ar), IW'(ac)};
  assign g_addr = (state == S_IDLE) ? in_addr : t_addr;

  // density as seen by the current term
  logic signed [DW-1:0] dsel, dsum;
  always_comb begin
    if (!exch && restricted_mode)
      dsel = DW'($signed(xq)) <<< 1;
    else if (!exch)
      dsel = DW'($signed(cq));
    else
      dsel = DW'($signed(xq));
    dsum = d1 + (u.hasb ? dsel : DW'(0));
    if (exch)
      dsum = -dsum;
  end

  logic signed [15:0] vh;
  logic signed [16:0] vl;
  assign vh = $signed(value_r[31:16]);
  assign vl = $signed({1'b0, value_r[15:0]});

  logic signed [71:0] rsum;
  assign rsum = $signed({{4{pa[51]}}, pa, 16'h0000}) + $signed({{19{pb[52]}}, pb})
              + 72'sd8388608;

  logic signed [GW:0] gsum;
  logic               ovf;
  logic [GW-1:0]      gnew;
  assign gsum = $signed({gq[GW-1], gq[GW-1:0]}) + $signed({term[GW-1], term});
  assign ovf  = gsum[GW] != gsum[GW-1];
  assign gnew = !ovf ? gsum[GW-1:0]
              : gsum[GW] ? {1'b1, {(GW-1){1'b0}}} : {1'b0, {(GW-1){1'b1}}};

  // memories
  always_ff @(posedge clk) begin
    cq <= cmem[d_addr];
    xq <= xmem[d_addr];
    gq <= gmem[g_addr];
    if (accept && !bad && in_op == ftec_pkg::OP_LOAD_C)
      cmem[in_addr] <= in_val;
    if (accept && !bad && in_op == ftec_pkg::OP_LOAD_X)
      xmem[in_addr] <= in_val;
    if (state == S_CLR)
      gmem[clr_cnt] <= '0;
    else if (state == S_WR)
      gmem[t_addr] <= {gq[GW] | ovf, gnew};
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ri <= in_i; rj <= in_j; rk <= in_k; rl <= in_l;
      value_r <= in_val;
      pat_c <= ftec_pkg::pattern(in_i, in_j, in_k, in_l, 1'b1);
      pat_x <= ftec_pkg::pattern(in_i, in_j, in_k, in_l, 1'b0);
    end
    if (state == S_RB) d1 <= dsel;
    if (state == S_DS) dreg <= dsum;
    if (state == S_MU) begin
      pa <= dreg * vh;
      pb <= dreg * vl;
    end
    if (state == S_RN) term <= rsum[71:24];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      basis_count <= 7'd64;
      restricted_mode <= 1'b1;
      term_select <= ftec_pkg::TS_BOTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ftec_pkg::REG_BASIS: basis_count <= cfg_wdata;
        ftec_pkg::REG_RESTR: restricted_mode <= cfg_wdata[0];
        ftec_pkg::REG_TERM:  term_select <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      m_tvalid <= 1'b0;
      exch <= 1'b0;
      step <= '0;
    end else begin
      if (res_load)
        m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready)
        m_tvalid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(DEPTH - 1))
            state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            if (in_op == ftec_pkg::OP_CLR) begin
              clr_cnt <= '0;
              state <= S_CLR;
            end else if (in_op <= ftec_pkg::OP_RDG && bad) begin
              m_tdata <= {{(ftec_pkg::OUT_W-GW-1){1'b0}}, 1'b1, {GW{1'b0}}};
            end else if (in_op == ftec_pkg::OP_RDG) begin
              state <= S_GRD;
            end else if (in_op == ftec_pkg::OP_INT) begin
              exch <= (term_select == ftec_pkg::TS_EXCH);
              step <= '0;
              state <= S_RA;
            end
          end
        end
        S_GRD: begin
          m_tdata <= {{(ftec_pkg::OUT_W-GW-2){1'b0}}, gq[GW], 1'b0, gq[GW-1:0]};
          state <= S_IDLE;
        end
        S_RA: state <= S_RB;
        S_RB: state <= S_DS;
        S_DS: state <= S_MU;
        S_MU: state <= S_RN;
        S_RN: state <= S_WR;
        S_WR: begin
          if (!u.last) begin
            step <= step + 1'b1;
            state <= S_RA;
          end else if (!exch && term_select != ftec_pkg::TS_COUL) begin
            exch <= 1'b1;
            step <= '0;
            state <= S_RA;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
